/* design/tbp_pkg.sv */
package tbp_pkg;

    // Geometry of the widget in pixels.
    localparam int OUTER_RADIUS = 180;
    localparam int BALL_RADIUS  = 30;
    localparam int TRAVEL_PX    = OUTER_RADIUS - BALL_RADIUS - 3;

    // Field and register widths.
    localparam int ANGLE_W   = 16;
    localparam int CFG_W     = 15;
    localparam int SHIFT_W   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int POS_W     = 9;
    localparam int FILT_W    = 18;

    // Datapath widths: magnitudes of the targets, products, square root and divider.
    localparam int LF_W    = 16;
    localparam int MAG_W   = 31;
    localparam int PROD_W  = 2 * MAG_W;
    localparam int MAG2_W  = PROD_W + 1;
    localparam int RAD_W   = 64;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int NUM_W   = MAG_W + LF_W;
    localparam int REM_W   = ROOT_W;
    localparam int CNT_W   = 5;
    localparam int SUM_W   = FILT_W + 1;

    // Travel length and rest position with 8 fraction bits.
    localparam logic [LF_W-1:0]   LF_PX   = LF_W'(TRAVEL_PX * 256);
    localparam longint unsigned   LF_LONG = longint'(TRAVEL_PX * 256);
    localparam logic [MAG2_W-1:0] LF_SQ   = MAG2_W'(LF_LONG * LF_LONG);
    localparam logic [SUM_W-1:0]  BASE_PX = SUM_W'((OUTER_RADIUS - BALL_RADIUS) * 256);

    // Iteration counts, loaded as the last count value.
    localparam logic [CNT_W-1:0] DIV_ANGLE_LAST = CNT_W'(MAG_W - 1);
    localparam logic [CNT_W-1:0] DIV_LIMIT_LAST = CNT_W'(LF_W - 1);
    localparam logic [CNT_W-1:0] ROOT_LAST      = CNT_W'(ROOT_W - 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROLL_LIMIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT       = 2'd3;

    localparam logic [CFG_W-1:0]   FULL_SCALE_RST  = 15'd5760;
    localparam logic [CFG_W-1:0]   PITCH_LIMIT_RST = 15'd384;
    localparam logic [CFG_W-1:0]   ROLL_LIMIT_RST  = 15'd448;
    localparam logic [SHIFT_W-1:0] SHIFT_RST       = 3'd2;

    typedef enum logic [2:0] {
        MUL_HOLD,
        MUL_ROLL_LF,
        MUL_PITCH_LF,
        MUL_TX_SQ,
        MUL_TY_SQ,
        MUL_TX_LF,
        MUL_TY_LF
    } tbp_mul_t;

    typedef enum logic [1:0] {
        DIV_NONE,
        DIV_ANGLE,
        DIV_LIMIT
    } tbp_div_t;

    typedef enum logic [2:0] {
        LD_NONE,
        LD_CAPTURE,
        LD_TX,
        LD_TY,
        LD_MAG2,
        LD_MAG2_ACC,
        LD_ROOT,
        LD_EMIT
    } tbp_ld_t;

    // Datapath controls of one microcode step.
    typedef struct packed {
        tbp_mul_t mul_sel;
        tbp_div_t div_op;
        tbp_ld_t  ld_op;
        logic     root_start;
    } tbp_ctrl_t;

    // Datapath status seen by the jump logic.
    typedef struct packed {
        logic no_beat;
        logic div_busy;
        logic root_busy;
        logic in_range;
        logic out_full;
    } tbp_flags_t;

    function automatic logic [ANGLE_W-1:0] abs_angle(input logic signed [ANGLE_W-1:0] v);
        abs_angle = v[ANGLE_W-1] ? ANGLE_W'(-v) : ANGLE_W'(v);
    endfunction

    function automatic logic signed [FILT_W-1:0] signed_target(input logic neg,
                                                              input logic [LF_W-1:0] mag);
        logic signed [FILT_W-1:0] t;
        t = signed'({{(FILT_W-LF_W){1'b0}}, mag});
        signed_target = neg ? -t : t;
    endfunction

endpackage

/* design/tbp_if.sv */
interface tbp_sample_if;
    import tbp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] roll_angle;

    modport source (output valid, output pitch_angle, output roll_angle, input ready);
    modport sink   (input valid, input pitch_angle, input roll_angle, output ready);
endinterface

interface tbp_result_if;
    import tbp_pkg::*;

    logic             valid;
    logic             ready;
    logic [POS_W-1:0] ball_x;
    logic [POS_W-1:0] ball_y;
    logic             is_level;

    modport source (output valid, output ball_x, output ball_y, output is_level, input ready);
    modport sink   (input valid, input ball_x, input ball_y, input is_level, output ready);
endinterface

/* design/tbp_divider.sv */
module tbp_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tbp_pkg::REM_W-1:0]   rem_init,
    input  logic [tbp_pkg::NUM_W-1:0]   num_init,
    input  logic [tbp_pkg::REM_W-1:0]   divisor,
    input  logic [tbp_pkg::CNT_W-1:0]   last_step,
    output logic                        busy,
    output logic [tbp_pkg::MAG_W-1:0]   quotient
);
    import tbp_pkg::*;

    logic [REM_W-1:0] rem_reg;
    logic [NUM_W-1:0] num_reg;
    logic [REM_W-1:0] div_reg;
    logic [MAG_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    logic [REM_W:0]   shifted;
    logic [REM_W+1:0] diff;
    logic             fits;

    // Restoring division, one quotient bit a cycle.
    assign shifted = {rem_reg, num_reg[NUM_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, div_reg};
    assign fits    = ~diff[REM_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= last_step;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= rem_init;
            num_reg <= num_init;
            div_reg <= divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[REM_W-1:0] : shifted[REM_W-1:0];
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[MAG_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
endmodule

/* design/tbp_sqrt.sv */
module tbp_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tbp_pkg::RAD_W-1:0]   radicand,
    output logic                        busy,
    output logic [tbp_pkg::ROOT_W-1:0]  root
);
    import tbp_pkg::*;

    localparam int RREM_W = ROOT_W + 2;

    logic [RAD_W-1:0]  rad_reg;
    logic [RREM_W-1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;

    logic [RREM_W+1:0] shifted;
    logic [RREM_W+1:0] trial;
    logic [RREM_W+2:0] diff;
    logic              fits;

    // Integer square root, one root bit (two radicand bits) a cycle.
    assign shifted = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign diff    = {1'b0, shifted} - {1'b0, trial};
    assign fits    = ~diff[RREM_W+2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= ROOT_LAST;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= fits ? diff[RREM_W-1:0] : shifted[RREM_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;
endmodule

/* design/tbp_sequencer.sv */
module tbp_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  tbp_pkg::tbp_flags_t flags,
    output tbp_pkg::tbp_ctrl_t  ctrl
);
    import tbp_pkg::*;

    localparam int STEP_W = 5;

    typedef enum logic [2:0] {
        J_NEXT,
        J_ALWAYS,
        J_NO_BEAT,
        J_DIV_BUSY,
        J_ROOT_BUSY,
        J_IN_RANGE,
        J_OUT_FULL
    } tbp_jump_t;

    typedef struct packed {
        tbp_ctrl_t         ctrl;
        tbp_jump_t         jump;
        logic [STEP_W-1:0] target;
    } tbp_uword_t;

    localparam logic [STEP_W-1:0] S_IDLE       = 5'd0;
    localparam logic [STEP_W-1:0] S_MUL_ROLL   = 5'd1;
    localparam logic [STEP_W-1:0] S_DIV_ROLL   = 5'd2;
    localparam logic [STEP_W-1:0] S_WAIT_ROLL  = 5'd3;
    localparam logic [STEP_W-1:0] S_DIV_PITCH  = 5'd4;
    localparam logic [STEP_W-1:0] S_WAIT_PITCH = 5'd5;
    localparam logic [STEP_W-1:0] S_SQ_X       = 5'd6;
    localparam logic [STEP_W-1:0] S_SQ_Y       = 5'd7;
    localparam logic [STEP_W-1:0] S_SUM        = 5'd8;
    localparam logic [STEP_W-1:0] S_TEST       = 5'd9;
    localparam logic [STEP_W-1:0] S_ROOT       = 5'd10;
    localparam logic [STEP_W-1:0] S_WAIT_ROOT  = 5'd11;
    localparam logic [STEP_W-1:0] S_MUL_X      = 5'd12;
    localparam logic [STEP_W-1:0] S_DIV_X      = 5'd13;
    localparam logic [STEP_W-1:0] S_WAIT_X     = 5'd14;
    localparam logic [STEP_W-1:0] S_DIV_Y      = 5'd15;
    localparam logic [STEP_W-1:0] S_WAIT_Y     = 5'd16;
    localparam logic [STEP_W-1:0] S_LOAD_Y     = 5'd17;
    localparam logic [STEP_W-1:0] S_EMIT       = 5'd18;
    localparam logic [STEP_W-1:0] S_DONE       = 5'd19;

    function automatic tbp_uword_t uw(input tbp_mul_t m, input tbp_div_t d, input tbp_ld_t l,
                                      input logic r, input tbp_jump_t j,
                                      input logic [STEP_W-1:0] t);
        tbp_uword_t w;
        w.ctrl.mul_sel    = m;
        w.ctrl.div_op     = d;
        w.ctrl.ld_op      = l;
        w.ctrl.root_start = r;
        w.jump            = j;
        w.target          = t;
        uw = w;
    endfunction

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    tbp_uword_t        word;
    logic              take_jump;

    // The program. A jump is taken when its condition holds, else the next step follows.
    always_comb
    begin
        case (step_reg)
            S_IDLE:       word = uw(MUL_HOLD,     DIV_NONE,  LD_CAPTURE,  1'b0, J_NO_BEAT,   S_IDLE);
            S_MUL_ROLL:   word = uw(MUL_ROLL_LF,  DIV_NONE,  LD_NONE,     1'b0, J_NEXT,      S_IDLE);
            S_DIV_ROLL:   word = uw(MUL_PITCH_LF, DIV_ANGLE, LD_NONE,     1'b0, J_NEXT,      S_IDLE);
            S_WAIT_ROLL:  word = uw(MUL_HOLD,     DIV_NONE,  LD_NONE,     1'b0, J_DIV_BUSY,  S_WAIT_ROLL);
            S_DIV_PITCH:  word = uw(MUL_HOLD,     DIV_ANGLE, LD_TX,       1'b0, J_NEXT,      S_IDLE);
            S_WAIT_PITCH: word = uw(MUL_HOLD,     DIV_NONE,  LD_NONE,     1'b0, J_DIV_BUSY,  S_WAIT_PITCH);
            S_SQ_X:       word = uw(MUL_TX_SQ,    DIV_NONE,  LD_TY,       1'b0, J_NEXT,      S_IDLE);
            S_SQ_Y:       word = uw(MUL_TY_SQ,    DIV_NONE,  LD_MAG2,     1'b0, J_NEXT,      S_IDLE);
            S_SUM:        word = uw(MUL_HOLD,     DIV_NONE,  LD_MAG2_ACC, 1'b0, J_NEXT,      S_IDLE);
            S_TEST:       word = uw(MUL_HOLD,     DIV_NONE,  LD_NONE,     1'b0, J_IN_RANGE,  S_EMIT);
            S_ROOT:       word = uw(MUL_HOLD,     DIV_NONE,  LD_NONE,     1'b1, J_NEXT,      S_IDLE);
            S_WAIT_ROOT:  word = uw(MUL_HOLD,     DIV_NONE,  LD_NONE,     1'b0, J_ROOT_BUSY, S_WAIT_ROOT);
            S_MUL_X:      word = uw(MUL_TX_LF,    DIV_NONE,  LD_ROOT,     1'b0, J_NEXT,      S_IDLE);
            S_DIV_X:      word = uw(MUL_TY_LF,    DIV_LIMIT, LD_NONE,     1'b0, J_NEXT,      S_IDLE);
            S_WAIT_X:     word = uw(MUL_HOLD,     DIV_NONE,  LD_NONE,     1'b0, J_DIV_BUSY,  S_WAIT_X);
            S_DIV_Y:      word = uw(MUL_HOLD,     DIV_LIMIT, LD_TX,       1'b0, J_NEXT,      S_IDLE);
            S_WAIT_Y:     word = uw(MUL_HOLD,     DIV_NONE,  LD_NONE,     1'b0, J_DIV_BUSY,  S_WAIT_Y);
            S_LOAD_Y:     word = uw(MUL_HOLD,     DIV_NONE,  LD_TY,       1'b0, J_NEXT,      S_IDLE);
            S_EMIT:       word = uw(MUL_HOLD,     DIV_NONE,  LD_EMIT,     1'b0, J_OUT_FULL,  S_EMIT);
            S_DONE:       word = uw(MUL_HOLD,     DIV_NONE,  LD_NONE,     1'b0, J_ALWAYS,    S_IDLE);
            default:      word = uw(MUL_HOLD,     DIV_NONE,  LD_NONE,     1'b0, J_ALWAYS,    S_IDLE);
        endcase
    end

    always_comb
    begin
        case (word.jump)
            J_NEXT:      take_jump = 1'b0;
            J_ALWAYS:    take_jump = 1'b1;
            J_NO_BEAT:   take_jump = flags.no_beat;
            J_DIV_BUSY:  take_jump = flags.div_busy;
            J_ROOT_BUSY: take_jump = flags.root_busy;
            J_IN_RANGE:  take_jump = flags.in_range;
            J_OUT_FULL:  take_jump = flags.out_full;
            default:     take_jump = 1'b1;
        endcase
        step_next = take_jump ? word.target : step_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign ctrl = word.ctrl;
endmodule

/* design/tilt_to_bubble_position_core.sv */
// Tilt to bubble position.
// A beat on the sample channel carries a pitch and a roll angle in signed
// 1/128-degree units. For each sample the block sends one beat on the result
// channel: the ball's top-left pixel position inside the level widget, after
// clamping to the rim and exponential smoothing, and a flag that is set when
// both angles lie under their level limits.
// Configuration registers are written through cfg_write_en, cfg_index and
// cfg_data, and should only be written while no sample is in flight.
// A small microcode program steps one multiplier, a one-bit-a-cycle divider
// and a one-bit-a-cycle square root unit through the sample. The result
// register loads after the two angle divisions and, when the target lies
// beyond the rim, after the square root and two short divisions as well.
// One sample is worked on at a time; the next is accepted once the result
// register has loaded and the program has passed its done step back to
// idle. The result register holds its beat while the receiver stalls, and
// the block still accepts and works on the next sample, waiting only if
// that sample is finished before the previous beat has gone. Reset clears
// the smoothing filter to the centre, restores the register defaults and
// empties the result register.
module tilt_to_bubble_position_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [tbp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tbp_pkg::CFG_W-1:0]       cfg_data,
    tbp_sample_if.sink                      sample,
    tbp_result_if.source                    result
);
    import tbp_pkg::*;

    tbp_ctrl_t  ctrl;
    tbp_flags_t flags;

    // Configuration.
    logic [CFG_W-1:0]   full_scale_reg;
    logic [CFG_W-1:0]   pitch_limit_reg;
    logic [CFG_W-1:0]   roll_limit_reg;
    logic [SHIFT_W-1:0] shift_reg;

    // Datapath registers.
    logic signed [ANGLE_W-1:0] pitch_reg;
    logic signed [ANGLE_W-1:0] roll_reg;
    logic [MAG_W-1:0]          tx_mag_reg;
    logic [MAG_W-1:0]          ty_mag_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [MAG2_W-1:0]         mag2_reg;
    logic [ROOT_W-1:0]         root_reg;
    logic signed [FILT_W-1:0]  filt_x_reg;
    logic signed [FILT_W-1:0]  filt_y_reg;

    logic             result_valid_reg;
    logic [POS_W-1:0] ball_x_reg;
    logic [POS_W-1:0] ball_y_reg;
    logic             is_level_reg;

    logic [ANGLE_W-1:0] pitch_mag;
    logic [ANGLE_W-1:0] roll_mag;
    logic [MAG_W-1:0]   mul_a;
    logic [MAG_W-1:0]   mul_b;
    logic [PROD_W-1:0]  prod;
    logic [CFG_W-1:0]   full_scale_eff;

    logic               div_start;
    logic [REM_W-1:0]   div_rem_init;
    logic [NUM_W-1:0]   div_num_init;
    logic [REM_W-1:0]   div_divisor;
    logic [CNT_W-1:0]   div_last;
    logic               div_busy;
    logic [MAG_W-1:0]   div_quo;

    logic               root_busy;
    logic [ROOT_W-1:0]  root;

    logic               capture;
    logic               emit;
    logic               out_full;

    logic signed [FILT_W-1:0] tgt_x;
    logic signed [FILT_W-1:0] tgt_y;
    logic signed [FILT_W-1:0] filt_x_next;
    logic signed [FILT_W-1:0] filt_y_next;
    logic signed [SUM_W-1:0]  pos_x;
    logic signed [SUM_W-1:0]  pos_y;
    logic                     level;

    tbp_sequencer u_sequencer (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    tbp_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .rem_init  (div_rem_init),
        .num_init  (div_num_init),
        .divisor   (div_divisor),
        .last_step (div_last),
        .busy      (div_busy),
        .quotient  (div_quo)
    );

    tbp_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.root_start),
        .radicand ({{(RAD_W-MAG2_W){1'b0}}, mag2_reg}),
        .busy     (root_busy),
        .root     (root)
    );

    assign pitch_mag      = abs_angle(pitch_reg);
    assign roll_mag       = abs_angle(roll_reg);
    assign full_scale_eff = (full_scale_reg == '0) ? CFG_W'(1) : full_scale_reg;

    always_comb
    begin
        case (ctrl.mul_sel)
            MUL_ROLL_LF:
            begin
                mul_a = MAG_W'(roll_mag);
                mul_b = MAG_W'(LF_PX);
            end
            MUL_PITCH_LF:
            begin
                mul_a = MAG_W'(pitch_mag);
                mul_b = MAG_W'(LF_PX);
            end
            MUL_TX_SQ:
            begin
                mul_a = tx_mag_reg;
                mul_b = tx_mag_reg;
            end
            MUL_TY_SQ:
            begin
                mul_a = ty_mag_reg;
                mul_b = ty_mag_reg;
            end
            MUL_TX_LF:
            begin
                mul_a = tx_mag_reg;
                mul_b = MAG_W'(LF_PX);
            end
            MUL_TY_LF:
            begin
                mul_a = ty_mag_reg;
                mul_b = MAG_W'(LF_PX);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // The angle division runs over the whole product. The clamping quotient
    // never exceeds the travel length, so its top bits go straight into the
    // partial remainder and only the low bits are worked through.
    always_comb
    begin
        div_start    = 1'b0;
        div_rem_init = '0;
        div_num_init = {prod_reg[MAG_W-1:0], {LF_W{1'b0}}};
        div_divisor  = REM_W'(full_scale_eff);
        div_last     = DIV_ANGLE_LAST;
        case (ctrl.div_op)
            DIV_ANGLE:
            begin
                div_start = 1'b1;
            end
            DIV_LIMIT:
            begin
                div_start    = 1'b1;
                div_rem_init = REM_W'(prod_reg[NUM_W-1:LF_W]);
                div_num_init = {prod_reg[LF_W-1:0], {MAG_W{1'b0}}};
                div_divisor  = root_reg;
                div_last     = DIV_LIMIT_LAST;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    assign out_full = result_valid_reg && !result.ready;
    assign capture  = (ctrl.ld_op == LD_CAPTURE) && sample.valid;
    assign emit     = (ctrl.ld_op == LD_EMIT) && !out_full;

    assign flags.no_beat   = !sample.valid;
    assign flags.div_busy  = div_busy;
    assign flags.root_busy = root_busy;
    assign flags.in_range  = (mag2_reg <= LF_SQ);
    assign flags.out_full  = out_full;

    // Smoothing: an arithmetic shift rounds the step towards minus infinity.
    assign tgt_x       = signed_target(roll_reg[ANGLE_W-1], tx_mag_reg[LF_W-1:0]);
    assign tgt_y       = signed_target(pitch_reg[ANGLE_W-1], ty_mag_reg[LF_W-1:0]);
    assign filt_x_next = filt_x_reg + ((tgt_x - filt_x_reg) >>> shift_reg);
    assign filt_y_next = filt_y_reg + ((tgt_y - filt_y_reg) >>> shift_reg);
    assign pos_x       = signed'(BASE_PX) + SUM_W'(filt_x_next);
    assign pos_y       = signed'(BASE_PX) + SUM_W'(filt_y_next);
    assign level       = (pitch_mag < {1'b0, pitch_limit_reg}) &&
                         (roll_mag < {1'b0, roll_limit_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_scale_reg   <= FULL_SCALE_RST;
            pitch_limit_reg  <= PITCH_LIMIT_RST;
            roll_limit_reg   <= ROLL_LIMIT_RST;
            shift_reg        <= SHIFT_RST;
            filt_x_reg       <= '0;
            filt_y_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_FULL_SCALE:  full_scale_reg  <= cfg_data;
                    CFG_PITCH_LIMIT: pitch_limit_reg <= cfg_data;
                    CFG_ROLL_LIMIT:  roll_limit_reg  <= cfg_data;
                    CFG_SHIFT:       shift_reg       <= cfg_data[SHIFT_W-1:0];
                    default:         ;
                endcase
            end
            if (emit)
            begin
                filt_x_reg       <= filt_x_next;
                filt_y_reg       <= filt_y_next;
                result_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            pitch_reg <= sample.pitch_angle;
            roll_reg  <= sample.roll_angle;
        end
        if (ctrl.mul_sel != MUL_HOLD)
        begin
            prod_reg <= prod;
        end
        case (ctrl.ld_op)
            LD_TX:       tx_mag_reg <= div_quo;
            LD_TY:       ty_mag_reg <= div_quo;
            LD_MAG2:     mag2_reg   <= {1'b0, prod_reg};
            LD_MAG2_ACC: mag2_reg   <= mag2_reg + {1'b0, prod_reg};
            LD_ROOT:     root_reg   <= root;
            default:     ;
        endcase
        if (emit)
        begin
            ball_x_reg   <= pos_x[POS_W+7:8];
            ball_y_reg   <= pos_y[POS_W+7:8];
            is_level_reg <= level;
        end
    end

    assign sample.ready    = (ctrl.ld_op == LD_CAPTURE);
    assign result.valid    = result_valid_reg;
    assign result.ball_x   = ball_x_reg;
    assign result.ball_y   = ball_y_reg;
    assign result.is_level = is_level_reg;
endmodule
